// ===== hw/rtl/ordered_list_table_unit_macros.svh =====
// assertion macros shared by the rtl
// each macro samples on clk and is switched off while arst_n is low
`ifndef ORDERED_LIST_TABLE_UNIT_MACROS_SVH
`define ORDERED_LIST_TABLE_UNIT_MACROS_SVH

// condition holds at every edge
`define OLT_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequence holds in the same cycle as the cause
`define OLT_ASSERT_SAME(lbl, cause, conseq, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cause) |-> (conseq)) else $error(msg);

// consequence holds in the cycle after the cause
`define OLT_ASSERT_NEXT(lbl, cause, conseq, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cause) |=> (conseq)) else $error(msg);

`endif

// ===== hw/rtl/olt_pkg.sv =====
package olt_pkg;

	localparam int KEY_W = 32;
	localparam int POS_W = 6;
	localparam int OP_W  = 3;
	localparam int ST_W  = 3;

	// request codes
	typedef enum logic [OP_W-1:0] {
		OP_APPEND  = 3'd0,
		OP_INSERT  = 3'd1,
		OP_LFIND   = 3'd2,
		OP_BFIND   = 3'd3,
		OP_DEL_AT  = 3'd4,
		OP_DEL_KEY = 3'd5,
		OP_SORT    = 3'd6,
		OP_READ    = 3'd7
	} op_t;

	// result status codes
	typedef enum logic [ST_W-1:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_BADPOS   = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	// datapath actions
	typedef enum logic [4:0] {
		A_NONE,
		A_LOAD,
		A_FAIL,
		A_APPEND,
		A_INS_INIT,
		A_INS_RD,
		A_INS_WR,
		A_INS_PUT,
		A_LIN_INIT,
		A_LIN_RD,
		A_LIN_STEP,
		A_DEL_INIT,
		A_DEL_RD,
		A_DEL_WR,
		A_DEL_END,
		A_BIN_INIT,
		A_BIN_RD,
		A_BIN_STEP,
		A_SORT_INIT,
		A_PASS,
		A_CUR,
		A_SRD,
		A_SEND,
		A_SCMP,
		A_RD_POS,
		A_RD_DONE
	} act_t;

	typedef struct packed {
		act_t    act;
		status_t code;
		logic    publish;
	} dp_cmd_t;

	typedef struct packed {
		op_t  op;
		logic full;
		logic empty;
		logic ins_ok;
		logic pos_ok;
		logic ins_more;
		logic i_lt_cnt;
		logic match;
		logic bin_open;
		logic key_lt;
		logic del_more;
		logic small_list;
		logic lim_zero;
		logic j_lt_lim;
	} dp_flags_t;

endpackage

// ===== hw/rtl/olt_ifs.sv =====
// request channel
interface olt_in_if;
	logic                              valid;
	logic                              ready;
	logic [olt_pkg::OP_W-1:0]          op;
	logic signed [olt_pkg::KEY_W-1:0]  key_value;
	logic [olt_pkg::POS_W-1:0]         slot_position;

	modport source(output valid, output op, output key_value, output slot_position,
		input ready);
	modport sink(input valid, input op, input key_value, input slot_position,
		output ready);
endinterface

// result channel
interface olt_out_if;
	logic                              valid;
	logic                              ready;
	logic [olt_pkg::ST_W-1:0]          status;
	logic [olt_pkg::POS_W-1:0]         found_position;
	logic signed [olt_pkg::KEY_W-1:0]  read_value;
	logic [olt_pkg::POS_W-1:0]         entry_count;

	modport source(output valid, output status, output found_position, output read_value,
		output entry_count, input ready);
	modport sink(input valid, input status, input found_position, input read_value,
		input entry_count, output ready);
endinterface

// ===== hw/rtl/olt_datapath.sv =====
`include "ordered_list_table_unit_macros.svh"

module olt_datapath #(
	parameter int DEPTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [olt_pkg::OP_W-1:0]         in_op,
	input  logic signed [olt_pkg::KEY_W-1:0] in_key,
	input  logic [olt_pkg::POS_W-1:0]        in_pos,
	input  olt_pkg::dp_cmd_t                 cmd,
	output olt_pkg::dp_flags_t               flags,
	output logic [olt_pkg::ST_W-1:0]         out_status,
	output logic [olt_pkg::POS_W-1:0]        out_pos,
	output logic signed [olt_pkg::KEY_W-1:0] out_value,
	output logic [olt_pkg::POS_W-1:0]        out_count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = ((CW > olt_pkg::POS_W) ? CW : olt_pkg::POS_W) + 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	logic signed [olt_pkg::KEY_W-1:0] mem [DEPTH];

	olt_pkg::op_t                     op_q;
	logic signed [olt_pkg::KEY_W-1:0] key_q;
	logic [olt_pkg::POS_W-1:0]        pos_q;
	logic [CW-1:0]                    cnt_q;
	logic [CW-1:0]                    i_q;
	logic [CW-1:0]                    lo_q;
	logic [CW-1:0]                    hi_q;
	logic [CW-1:0]                    mid_q;
	logic [CW-1:0]                    lim_q;
	logic signed [olt_pkg::KEY_W-1:0] cur_q;
	logic signed [olt_pkg::KEY_W-1:0] rdata_q;
	olt_pkg::status_t                 res_st_q;
	logic [olt_pkg::POS_W-1:0]        res_pos_q;
	logic signed [olt_pkg::KEY_W-1:0] res_val_q;
	olt_pkg::status_t                 out_st_q;
	logic [olt_pkg::POS_W-1:0]        out_pos_q;
	logic signed [olt_pkg::KEY_W-1:0] out_val_q;
	logic [olt_pkg::POS_W-1:0]        out_cnt_q;

	logic [XW-1:0]  pos_x, cnt_x, i_x, mid_x;
	logic [XW-1:0]  app_pos_x, hit_pos_x, mid_pos_x, pm1_x;
	logic [CW:0]    mid_sum;
	logic [CW-1:0]  mid_c, ip1, im1;
	logic           rd_en, wr_en;
	logic [AW-1:0]  raddr, waddr;
	logic signed [olt_pkg::KEY_W-1:0] wdata;
	logic           new_lt_cur;

	// widened copies for compares
	assign pos_x     = XW'(pos_q);
	assign cnt_x     = XW'(cnt_q);
	assign i_x       = XW'(i_q);
	assign mid_x     = XW'(mid_q);
	assign app_pos_x = cnt_x + XW'(1);
	assign hit_pos_x = i_x + XW'(1);
	assign mid_pos_x = mid_x + XW'(1);
	assign pm1_x     = pos_x - XW'(1);
	assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q} - (CW+1)'(1);
	assign mid_c     = mid_sum[CW:1];
	assign ip1       = i_q + CW'(1);
	assign im1       = i_q - CW'(1);
	assign new_lt_cur = rdata_q < cur_q;

	// status towards the controller
	always_comb begin
		flags.op         = op_q;
		flags.full       = cnt_q >= DEPTH_C;
		flags.empty      = cnt_q == '0;
		flags.ins_ok     = (pos_x != '0) && (pos_x <= app_pos_x);
		flags.pos_ok     = (pos_x != '0) && (pos_x <= cnt_x);
		flags.ins_more   = i_x >= pos_x;
		flags.i_lt_cnt   = i_q < cnt_q;
		flags.match      = rdata_q == key_q;
		flags.bin_open   = lo_q < hi_q;
		flags.key_lt     = key_q < rdata_q;
		flags.del_more   = hit_pos_x < cnt_x;
		flags.small_list = cnt_q < CW'(2);
		flags.lim_zero   = lim_q == '0;
		flags.j_lt_lim   = i_q < lim_q;
	end

	// memory port control
	always_comb begin
		rd_en = 1'b0;
		wr_en = 1'b0;
		raddr = '0;
		waddr = '0;
		wdata = key_q;
		case (cmd.act)
			olt_pkg::A_APPEND: begin
				wr_en = 1'b1;
				waddr = cnt_q[AW-1:0];
			end
			olt_pkg::A_INS_RD: begin
				rd_en = 1'b1;
				raddr = im1[AW-1:0];
			end
			olt_pkg::A_INS_WR: begin
				wr_en = 1'b1;
				waddr = i_q[AW-1:0];
				wdata = rdata_q;
			end
			olt_pkg::A_INS_PUT: begin
				wr_en = 1'b1;
				waddr = i_q[AW-1:0];
			end
			olt_pkg::A_LIN_RD: begin
				rd_en = 1'b1;
				raddr = i_q[AW-1:0];
			end
			olt_pkg::A_DEL_RD, olt_pkg::A_SRD: begin
				rd_en = 1'b1;
				raddr = ip1[AW-1:0];
			end
			olt_pkg::A_DEL_WR: begin
				wr_en = 1'b1;
				waddr = i_q[AW-1:0];
				wdata = rdata_q;
			end
			olt_pkg::A_BIN_RD: begin
				rd_en = 1'b1;
				raddr = mid_c[AW-1:0];
			end
			olt_pkg::A_PASS: begin
				rd_en = 1'b1;
				raddr = '0;
			end
			olt_pkg::A_SEND: begin
				wr_en = 1'b1;
				waddr = i_q[AW-1:0];
				wdata = cur_q;
			end
			olt_pkg::A_SCMP: begin
				wr_en = 1'b1;
				waddr = i_q[AW-1:0];
				wdata = new_lt_cur ? rdata_q : cur_q;
			end
			olt_pkg::A_RD_POS: begin
				rd_en = 1'b1;
				raddr = pm1_x[AW-1:0];
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// entry store with registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case (cmd.act)
				olt_pkg::A_APPEND, olt_pkg::A_INS_PUT: cnt_q <= cnt_q + CW'(1);
				olt_pkg::A_DEL_END:                    cnt_q <= cnt_q - CW'(1);
				default:                               cnt_q <= cnt_q;
			endcase
		end
	end

	// working registers and result
	always_ff @(posedge clk) begin
		case (cmd.act)
			olt_pkg::A_LOAD: begin
				op_q      <= olt_pkg::op_t'(in_op);
				key_q     <= in_key;
				pos_q     <= in_pos;
				res_st_q  <= olt_pkg::ST_OK;
				res_pos_q <= '0;
				res_val_q <= '0;
			end
			olt_pkg::A_FAIL: begin
				res_st_q  <= cmd.code;
				res_pos_q <= '0;
			end
			olt_pkg::A_APPEND:   res_pos_q <= app_pos_x[olt_pkg::POS_W-1:0];
			olt_pkg::A_INS_INIT: i_q <= cnt_q;
			olt_pkg::A_INS_WR:   i_q <= im1;
			olt_pkg::A_INS_PUT:  res_pos_q <= pos_q;
			olt_pkg::A_LIN_INIT: i_q <= '0;
			olt_pkg::A_LIN_STEP: begin
				if (rdata_q == key_q) begin
					res_pos_q <= hit_pos_x[olt_pkg::POS_W-1:0];
				end else begin
					i_q <= ip1;
				end
			end
			olt_pkg::A_DEL_INIT: begin
				i_q       <= pm1_x[CW-1:0];
				res_pos_q <= pos_q;
			end
			olt_pkg::A_DEL_WR: i_q <= ip1;
			olt_pkg::A_BIN_INIT: begin
				lo_q <= '0;
				hi_q <= cnt_q;
			end
			olt_pkg::A_BIN_RD: mid_q <= mid_c;
			olt_pkg::A_BIN_STEP: begin
				if (rdata_q == key_q) begin
					res_pos_q <= mid_pos_x[olt_pkg::POS_W-1:0];
				end else if (key_q < rdata_q) begin
					hi_q <= mid_q;
				end else begin
					lo_q <= mid_pos_x[CW-1:0];
				end
			end
			olt_pkg::A_SORT_INIT: lim_q <= cnt_q - CW'(1);
			olt_pkg::A_PASS:      i_q <= '0;
			olt_pkg::A_CUR:       cur_q <= rdata_q;
			olt_pkg::A_SEND:      lim_q <= lim_q - CW'(1);
			olt_pkg::A_SCMP: begin
				if (!new_lt_cur) begin
					cur_q <= rdata_q;
				end
				i_q <= ip1;
			end
			olt_pkg::A_RD_DONE: begin
				res_val_q <= rdata_q;
				res_pos_q <= pos_q;
			end
			default: begin
				i_q <= i_q;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			out_st_q  <= res_st_q;
			out_pos_q <= res_pos_q;
			out_val_q <= res_val_q;
			out_cnt_q <= cnt_x[olt_pkg::POS_W-1:0];
		end
	end

	assign out_status = out_st_q;
	assign out_pos    = out_pos_q;
	assign out_value  = out_val_q;
	assign out_count  = out_cnt_q;

	`OLT_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= DEPTH_C, "entry count above depth")
	`OLT_ASSERT_SAME(a_grow_room, (cmd.act == olt_pkg::A_APPEND) || (cmd.act == olt_pkg::A_INS_PUT), cnt_q < DEPTH_C, "entry added to a full list")
	`OLT_ASSERT_NEXT(a_grow_step, cmd.act == olt_pkg::A_APPEND, cnt_q == $past(cnt_q) + CW'(1), "append did not bump the count")
	`OLT_ASSERT_SAME(a_bin_window, cmd.act == olt_pkg::A_BIN_RD, lo_q < hi_q, "halving probe outside window")

endmodule

// ===== hw/rtl/olt_ctrl.sv =====
module olt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  olt_pkg::dp_flags_t flags,
	output olt_pkg::dp_cmd_t   cmd
);

	typedef enum logic [4:0] {
		S_IDLE,
		S_DISPATCH,
		S_INS_CHK,
		S_INS_WR,
		S_LIN_RD,
		S_LIN_CMP,
		S_DEL_CHK,
		S_DEL_WR,
		S_BIN_RD,
		S_BIN_CMP,
		S_PASS,
		S_CUR,
		S_SRD,
		S_SCMP,
		S_RD_WAIT,
		S_FINISH
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

	// next state and datapath action
	always_comb begin
		state_d     = state_q;
		cmd.act     = olt_pkg::A_NONE;
		cmd.code    = olt_pkg::ST_OK;
		cmd.publish = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.act = olt_pkg::A_LOAD;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_d = S_FINISH;
				case (flags.op)
					olt_pkg::OP_APPEND: begin
						if (flags.full) begin
							cmd.act  = olt_pkg::A_FAIL;
							cmd.code = olt_pkg::ST_FULL;
						end else begin
							cmd.act = olt_pkg::A_APPEND;
						end
					end
					olt_pkg::OP_INSERT: begin
						if (flags.full) begin
							cmd.act  = olt_pkg::A_FAIL;
							cmd.code = olt_pkg::ST_FULL;
						end else if (!flags.ins_ok) begin
							cmd.act  = olt_pkg::A_FAIL;
							cmd.code = olt_pkg::ST_BADPOS;
						end else begin
							cmd.act = olt_pkg::A_INS_INIT;
							state_d = S_INS_CHK;
						end
					end
					olt_pkg::OP_LFIND: begin
						cmd.act = olt_pkg::A_LIN_INIT;
						state_d = S_LIN_RD;
					end
					olt_pkg::OP_BFIND: begin
						cmd.act = olt_pkg::A_BIN_INIT;
						state_d = S_BIN_RD;
					end
					olt_pkg::OP_DEL_AT: begin
						if (flags.empty) begin
							cmd.act  = olt_pkg::A_FAIL;
							cmd.code = olt_pkg::ST_EMPTY;
						end else if (!flags.pos_ok) begin
							cmd.act  = olt_pkg::A_FAIL;
							cmd.code = olt_pkg::ST_BADPOS;
						end else begin
							cmd.act = olt_pkg::A_DEL_INIT;
							state_d = S_DEL_CHK;
						end
					end
					olt_pkg::OP_DEL_KEY: begin
						if (flags.empty) begin
							cmd.act  = olt_pkg::A_FAIL;
							cmd.code = olt_pkg::ST_EMPTY;
						end else begin
							cmd.act = olt_pkg::A_LIN_INIT;
							state_d = S_LIN_RD;
						end
					end
					olt_pkg::OP_SORT: begin
						if (!flags.small_list) begin
							cmd.act = olt_pkg::A_SORT_INIT;
							state_d = S_PASS;
						end
					end
					default: begin
						if (!flags.pos_ok) begin
							cmd.act  = olt_pkg::A_FAIL;
							cmd.code = olt_pkg::ST_BADPOS;
						end else begin
							cmd.act = olt_pkg::A_RD_POS;
							state_d = S_RD_WAIT;
						end
					end
				endcase
			end
			// shift entries up one place, top down
			S_INS_CHK: begin
				if (flags.ins_more) begin
					cmd.act = olt_pkg::A_INS_RD;
					state_d = S_INS_WR;
				end else begin
					cmd.act = olt_pkg::A_INS_PUT;
					state_d = S_FINISH;
				end
			end
			S_INS_WR: begin
				cmd.act = olt_pkg::A_INS_WR;
				state_d = S_INS_CHK;
			end
			// linear scan
			S_LIN_RD: begin
				if (flags.i_lt_cnt) begin
					cmd.act = olt_pkg::A_LIN_RD;
					state_d = S_LIN_CMP;
				end else begin
					cmd.act  = olt_pkg::A_FAIL;
					cmd.code = olt_pkg::ST_NOTFOUND;
					state_d  = S_FINISH;
				end
			end
			S_LIN_CMP: begin
				cmd.act = olt_pkg::A_LIN_STEP;
				if (!flags.match) begin
					state_d = S_LIN_RD;
				end else if (flags.op == olt_pkg::OP_DEL_KEY) begin
					state_d = S_DEL_CHK;
				end else begin
					state_d = S_FINISH;
				end
			end
			// close the gap, bottom up
			S_DEL_CHK: begin
				if (flags.del_more) begin
					cmd.act = olt_pkg::A_DEL_RD;
					state_d = S_DEL_WR;
				end else begin
					cmd.act = olt_pkg::A_DEL_END;
					state_d = S_FINISH;
				end
			end
			S_DEL_WR: begin
				cmd.act = olt_pkg::A_DEL_WR;
				state_d = S_DEL_CHK;
			end
			// halving search
			S_BIN_RD: begin
				if (flags.bin_open) begin
					cmd.act = olt_pkg::A_BIN_RD;
					state_d = S_BIN_CMP;
				end else begin
					cmd.act  = olt_pkg::A_FAIL;
					cmd.code = olt_pkg::ST_NOTFOUND;
					state_d  = S_FINISH;
				end
			end
			S_BIN_CMP: begin
				cmd.act = olt_pkg::A_BIN_STEP;
				state_d = flags.match ? S_FINISH : S_BIN_RD;
			end
			// bubble passes, the largest key rides in cur
			S_PASS: begin
				if (flags.lim_zero) begin
					state_d = S_FINISH;
				end else begin
					cmd.act = olt_pkg::A_PASS;
					state_d = S_CUR;
				end
			end
			S_CUR: begin
				cmd.act = olt_pkg::A_CUR;
				state_d = S_SRD;
			end
			S_SRD: begin
				if (flags.j_lt_lim) begin
					cmd.act = olt_pkg::A_SRD;
					state_d = S_SCMP;
				end else begin
					cmd.act = olt_pkg::A_SEND;
					state_d = S_PASS;
				end
			end
			S_SCMP: begin
				cmd.act = olt_pkg::A_SCMP;
				state_d = S_SRD;
			end
			S_RD_WAIT: begin
				cmd.act = olt_pkg::A_RD_DONE;
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/ordered_list_table_unit.sv =====
// append, failed checks and sort of under two keys go from dispatch straight to the finish state,
// read passes through a wait state for the entry before it
// insert and delete read then write each shifted entry, finds read then compare each probe
// sort runs bubble passes through the single-port entry store
// one request at a time; the next is taken the cycle after the previous result is registered
// arst_n clears the count, the controller and the result valid; entries hold no reset value
module ordered_list_table_unit #(
	parameter int DEPTH = 32
) (
	input logic       clk,
	input logic       arst_n,
	olt_in_if.sink    req,
	olt_out_if.source rsp
);

	olt_pkg::dp_cmd_t   cmd;
	olt_pkg::dp_flags_t flags;

	// sequencer
	olt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.flags     (flags),
		.cmd       (cmd)
	);

	// entry store and working registers
	olt_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_op      (req.op),
		.in_key     (req.key_value),
		.in_pos     (req.slot_position),
		.cmd        (cmd),
		.flags      (flags),
		.out_status (rsp.status),
		.out_pos    (rsp.found_position),
		.out_value  (rsp.read_value),
		.out_count  (rsp.entry_count)
	);

endmodule

// ===== tb/tb_ordered_list_table_unit.sv =====
`timescale 1ns / 100ps

module tb_ordered_list_table_unit;

	localparam int DEPTH = 32;

	typedef struct {
		olt_pkg::status_t                 status;
		logic [olt_pkg::POS_W-1:0]        found_position;
		logic signed [olt_pkg::KEY_W-1:0] read_value;
		logic [olt_pkg::POS_W-1:0]        entry_count;
	} list_result_t;

	logic clk;
	logic arst_n;

	olt_in_if  req();
	olt_out_if rsp();

	ordered_list_table_unit #(.DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	// shadow copy of the list
	logic signed [olt_pkg::KEY_W-1:0] shadow_keys[DEPTH];
	int                               shadow_len;

	list_result_t pending_results[$];
	int           fail_count;
	int           beats_checked;
	int           op_seen[8];
	int           status_seen[5];
	int           send_idle_pct;
	int           recv_idle_pct;
	int           recv_hold_cycles;

	// clock
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// list behaviour: updates the shadow list and returns the expected beat
	function automatic list_result_t predict_list_op(olt_pkg::op_t op,
		logic signed [olt_pkg::KEY_W-1:0] key, logic [olt_pkg::POS_W-1:0] pos);
		list_result_t r;
		int idx;
		int lo;
		int hi;
		int mid;
		logic signed [olt_pkg::KEY_W-1:0] t;
		r.status = olt_pkg::ST_OK;
		r.found_position = '0;
		r.read_value = '0;
		idx = -1;
		case (op)
			olt_pkg::OP_APPEND: begin
				if (shadow_len >= DEPTH) begin
					r.status = olt_pkg::ST_FULL;
				end else begin
					shadow_keys[shadow_len] = key;
					shadow_len++;
					r.found_position = olt_pkg::POS_W'(shadow_len);
				end
			end
			olt_pkg::OP_INSERT: begin
				if (shadow_len >= DEPTH) begin
					r.status = olt_pkg::ST_FULL;
				end else if (pos < 1 || pos > shadow_len + 1) begin
					r.status = olt_pkg::ST_BADPOS;
				end else begin
					for (int i = shadow_len; i >= pos; i--)
						shadow_keys[i] = shadow_keys[i-1];
					shadow_keys[pos-1] = key;
					shadow_len++;
					r.found_position = pos;
				end
			end
			olt_pkg::OP_LFIND, olt_pkg::OP_DEL_KEY: begin
				if (op == olt_pkg::OP_DEL_KEY && shadow_len == 0) begin
					r.status = olt_pkg::ST_EMPTY;
				end else begin
					for (int i = 0; i < shadow_len && idx < 0; i++)
						if (shadow_keys[i] == key) idx = i;
					if (idx < 0) begin
						r.status = olt_pkg::ST_NOTFOUND;
					end else begin
						r.found_position = olt_pkg::POS_W'(idx + 1);
						if (op == olt_pkg::OP_DEL_KEY) begin
							for (int i = idx; i + 1 < shadow_len; i++)
								shadow_keys[i] = shadow_keys[i+1];
							shadow_len--;
						end
					end
				end
			end
			olt_pkg::OP_BFIND: begin
				lo = 0;
				hi = shadow_len - 1;
				while (hi >= lo && idx < 0) begin
					mid = (lo + hi) / 2;
					if (shadow_keys[mid] == key) idx = mid;
					else if (key < shadow_keys[mid]) hi = mid - 1;
					else lo = mid + 1;
				end
				if (idx < 0) r.status = olt_pkg::ST_NOTFOUND;
				else r.found_position = olt_pkg::POS_W'(idx + 1);
			end
			olt_pkg::OP_DEL_AT: begin
				if (shadow_len == 0) begin
					r.status = olt_pkg::ST_EMPTY;
				end else if (pos < 1 || pos > shadow_len) begin
					r.status = olt_pkg::ST_BADPOS;
				end else begin
					for (int i = pos - 1; i + 1 < shadow_len; i++)
						shadow_keys[i] = shadow_keys[i+1];
					shadow_len--;
					r.found_position = pos;
				end
			end
			olt_pkg::OP_SORT: begin
				for (int i = 0; i + 1 < shadow_len; i++)
					for (int j = 0; j + 1 < shadow_len - i; j++)
						if (shadow_keys[j+1] < shadow_keys[j]) begin
							t = shadow_keys[j];
							shadow_keys[j] = shadow_keys[j+1];
							shadow_keys[j+1] = t;
						end
			end
			default: begin
				if (pos < 1 || pos > shadow_len) begin
					r.status = olt_pkg::ST_BADPOS;
				end else begin
					r.read_value = shadow_keys[pos-1];
					r.found_position = pos;
				end
			end
		endcase
		r.entry_count = olt_pkg::POS_W'(shadow_len);
		return r;
	endfunction

	// send one request beat, predicting its result at acceptance
	task automatic send_request(olt_pkg::op_t op, logic signed [olt_pkg::KEY_W-1:0] key,
		logic [olt_pkg::POS_W-1:0] pos);
		int gap;
		gap = 0;
		while ($urandom_range(99, 0) < send_idle_pct) gap++;
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid         <= 1'b1;
		req.op            <= op;
		req.key_value     <= key;
		req.slot_position <= pos;
		do @(posedge clk); while (!req.ready);
		pending_results.push_back(predict_list_op(op, key, pos));
		op_seen[op]++;
	endtask

	task automatic idle_request();
		req.valid <= 1'b0;
		@(posedge clk);
	endtask

	// result ready with random stalls and long hold-offs
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else if (recv_hold_cycles > 0) begin
			rsp.ready <= 1'b0;
			recv_hold_cycles <= recv_hold_cycles - 1;
		end else begin
			rsp.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
		end
	end

	// compare each result beat with the oldest expectation
	always @(posedge clk) begin
		list_result_t e;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_results.size() == 0) begin
				$error("result beat with nothing expected");
				fail_count++;
			end else begin
				e = pending_results.pop_front();
				beats_checked++;
				if (e.status <= olt_pkg::ST_NOTFOUND) status_seen[e.status]++;
				if (rsp.status !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, rsp.status);
					fail_count++;
				end
				if (rsp.found_position !== e.found_position) begin
					$error("found_position: expected %0d, got %0d",
						e.found_position, rsp.found_position);
					fail_count++;
				end
				if (rsp.read_value !== e.read_value) begin
					$error("read_value: expected %0d, got %0d", e.read_value, rsp.read_value);
					fail_count++;
				end
				if (rsp.entry_count !== e.entry_count) begin
					$error("entry_count: expected %0d, got %0d", e.entry_count, rsp.entry_count);
					fail_count++;
				end
			end
		end
	end

	task automatic wait_drained();
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// empty list, extremes, every op and the empty, bad-position and not-found statuses
	task automatic test_directed();
		send_request(olt_pkg::OP_READ, 32'sd0, 6'd0);
		send_request(olt_pkg::OP_READ, 32'sd0, 6'd1);
		send_request(olt_pkg::OP_DEL_AT, 32'sd0, 6'd1);
		send_request(olt_pkg::OP_DEL_KEY, 32'sd5, 6'd0);
		send_request(olt_pkg::OP_LFIND, 32'sd5, 6'd0);
		send_request(olt_pkg::OP_BFIND, 32'sd5, 6'd0);
		send_request(olt_pkg::OP_SORT, 32'sd0, 6'd0);
		send_request(olt_pkg::OP_APPEND, 32'h7fffffff, 6'd0);
		send_request(olt_pkg::OP_APPEND, 32'h80000000, 6'd63);
		send_request(olt_pkg::OP_INSERT, 32'sd0, 6'd0);
		send_request(olt_pkg::OP_INSERT, -32'sd1, 6'd1);
		send_request(olt_pkg::OP_INSERT, 32'sd7, 6'd4);
		send_request(olt_pkg::OP_INSERT, 32'sd9, 6'd6);
		send_request(olt_pkg::OP_INSERT, 32'sd9, 6'd63);
		send_request(olt_pkg::OP_BFIND, 32'sd7, 6'd0);
		send_request(olt_pkg::OP_LFIND, 32'h80000000, 6'd0);
		send_request(olt_pkg::OP_SORT, 32'sd0, 6'd0);
		send_request(olt_pkg::OP_BFIND, 32'h7fffffff, 6'd0);
		send_request(olt_pkg::OP_BFIND, 32'sd3, 6'd0);
		send_request(olt_pkg::OP_READ, 32'sd0, 6'd4);
		send_request(olt_pkg::OP_READ, 32'sd0, 6'd5);
		send_request(olt_pkg::OP_DEL_AT, 32'sd0, 6'd5);
		send_request(olt_pkg::OP_DEL_KEY, 32'sd123, 6'd0);
		send_request(olt_pkg::OP_DEL_KEY, -32'sd1, 6'd0);
		send_request(olt_pkg::OP_DEL_AT, 32'sd0, 6'd1);
	endtask

	// fill to the top, overflow, then drain again
	task automatic test_full_list();
		while (shadow_len < DEPTH)
			send_request(olt_pkg::OP_APPEND, $urandom_range(20, 0), 6'd0);
		send_request(olt_pkg::OP_APPEND, 32'sd1, 6'd0);
		send_request(olt_pkg::OP_INSERT, 32'sd1, 6'd1);
		send_request(olt_pkg::OP_READ, 32'sd0, 6'(DEPTH));
		send_request(olt_pkg::OP_SORT, 32'sd0, 6'd0);
		send_request(olt_pkg::OP_BFIND, 32'sd10, 6'd0);
		while (shadow_len > 0)
			send_request(olt_pkg::OP_DEL_AT, 32'sd0,
				olt_pkg::POS_W'($urandom_range(shadow_len, 1)));
	endtask

	// random requests biased towards valid positions and repeated keys
	task automatic test_random(int n);
		olt_pkg::op_t op;
		logic signed [olt_pkg::KEY_W-1:0] key;
		logic [olt_pkg::POS_W-1:0] pos;
		int r;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99, 0);
			if (r < 3) op = olt_pkg::OP_SORT;
			else if (r < 23) op = (shadow_len < 24) ? olt_pkg::OP_APPEND : olt_pkg::OP_DEL_AT;
			else if (r < 38) op = olt_pkg::OP_INSERT;
			else op = olt_pkg::op_t'($urandom_range(7, 2));
			if (op == olt_pkg::OP_SORT && $urandom_range(1, 0)) op = olt_pkg::OP_READ;
			if ($urandom_range(3, 0) == 0) key = $urandom;
			else if (shadow_len > 0 && $urandom_range(1, 0))
				key = shadow_keys[$urandom_range(shadow_len - 1, 0)];
			else key = $signed($urandom_range(16, 0)) - 8;
			if ($urandom_range(9, 0) == 0) pos = olt_pkg::POS_W'($urandom_range(63, 0));
			else pos = olt_pkg::POS_W'($urandom_range(shadow_len + 1, 1));
			send_request(op, key, pos);
		end
	endtask

	// hold the result side off while requests keep coming
	task automatic test_backpressure();
		recv_hold_cycles <= 400;
		for (int k = 0; k < 12; k++) send_request(olt_pkg::OP_APPEND, $urandom, 6'd0);
		send_request(olt_pkg::OP_READ, 32'sd0, 6'd1);
		idle_request();
		wait_drained();
	endtask

	initial begin
		req.valid         <= 1'b0;
		req.op            <= olt_pkg::OP_APPEND;
		req.key_value     <= '0;
		req.slot_position <= '0;
		arst_n = 1'b0;
		shadow_len = 0;
		fail_count = 0;
		beats_checked = 0;
		recv_hold_cycles = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		foreach (op_seen[i]) op_seen[i] = 0;
		foreach (status_seen[i]) status_seen[i] = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 14;
		recv_idle_pct = 59;
		test_directed();
		test_full_list();
		test_random(140);
		send_idle_pct = 59;
		recv_idle_pct = 14;
		test_random(140);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(140);
		test_backpressure();

		idle_request();
		wait_drained();
		repeat (1200) @(posedge clk);
		$display("checked %0d result beats; ops append..read: %0d %0d %0d %0d %0d %0d %0d %0d",
			beats_checked, op_seen[0], op_seen[1], op_seen[2], op_seen[3],
			op_seen[4], op_seen[5], op_seen[6], op_seen[7]);
		$display("statuses ok/full/empty/badpos/notfound: %0d %0d %0d %0d %0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// watchdog
	initial begin
		#20ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/olt_pkg.sv
hw/rtl/olt_ifs.sv
hw/rtl/olt_datapath.sv
hw/rtl/olt_ctrl.sv
hw/rtl/ordered_list_table_unit.sv
tb/tb_ordered_list_table_unit.sv
